// ===== rtl/core/fecf_pkg.sv =====
// ----------------------------------------------------------------------------
// fecf_pkg
// Shared types and constants of the feedback echo comb filter.
// ----------------------------------------------------------------------------
`default_nettype none

package fecf_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_W    = 15;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;

  localparam logic [CFG_W-1:0] GAIN_RESET   = 15'd19661;
  localparam logic [CFG_W-1:0] LENGTH_RESET = 15'd16000;

  // register select, taken from paddr[2]
  typedef enum logic {
    REG_GAIN   = 1'b0,
    REG_LENGTH = 1'b1
  } cfg_reg_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

`default_nettype wire

// ===== rtl/core/fecf_in_if.sv =====
// ----------------------------------------------------------------------------
// fecf_in_if
// Valid/ready channel carrying dry input samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface fecf_in_if
  import fecf_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fecf_out_if.sv =====
// ----------------------------------------------------------------------------
// fecf_out_if
// Valid/ready channel carrying filtered output samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface fecf_out_if
  import fecf_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/feedback_echo_comb_filter_unit.sv =====
// ----------------------------------------------------------------------------
// feedback_echo_comb_filter_unit
// Fading echo: out = sat16(in + trunc(gain * delayed)), written back to delay.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one signed 16-bit dry sample per beat, out_o one saturated
//   echo-mixed sample per beat, in the same order. The APB port holds the
//   Q0.15 feedback gain (0x0) and the delay length in samples (0x4); write
//   them only while no beat is in flight.
// Pipeline: compute stage, then output register. Throughput: one beat per
//   cycle while out_o is not held. The delay line is a single synchronous
//   RAM read when a beat is accepted and written when the beat leaves the
//   compute stage; a write that lands on the entry being read in the same
//   cycle (short delays) is forwarded into the next stage.
// Reset: the delay position goes to zero and the gain and length take their
//   reset values. The RAM is not swept: a fill mark records how far the
//   position has written, and entries at or above it read as zero, so no
//   beat waits after reset.
// Stall: while out_o is held, one more beat is taken into the compute stage;
//   then in_i.ready drops until the output register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module feedback_echo_comb_filter_unit
  import fecf_pkg::*;
#(
  parameter int unsigned DELAY_DEPTH = 16384
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  fecf_in_if.sink             in_i,
  fecf_out_if.source          out_o,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [APB_AW-1:0]   paddr,
  input  wire  [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  localparam int unsigned AW = $clog2(DELAY_DEPTH);
  localparam int unsigned CW = $clog2(DELAY_DEPTH + 1);
  localparam int unsigned LW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(DELAY_DEPTH);

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] gain_q, gain_d;
  logic [CFG_W-1:0] len_q, len_d;
  logic             cfg_wr;
  cfg_reg_e         cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[2]);

  always_comb begin
    gain_d = gain_q;
    len_d  = len_q;
    prdata = '0;
    unique case (cfg_sel)
      REG_GAIN: begin
        prdata = APB_DW'(gain_q);
        if (cfg_wr) gain_d = pwdata[CFG_W-1:0];
      end
      REG_LENGTH: begin
        prdata = APB_DW'(len_q);
        if (cfg_wr) len_d = pwdata[CFG_W-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
      len_q  <= LENGTH_RESET;
    end else begin
      gain_q <= gain_d;
      len_q  <= len_d;
    end
  end

  // effective loop length: zero acts as one, clipped to the RAM depth
  logic [LW-1:0] len_ext;
  logic [CW-1:0] len_eff;

  always_comb begin
    len_ext = LW'(len_q);
    if (len_ext == '0) begin
      len_eff = CW'(1);
    end else if (len_ext > DEPTH_L) begin
      len_eff = CW'(DELAY_DEPTH);
    end else begin
      len_eff = len_ext[CW-1:0];
    end
  end

  // --------------------------------------------------------------- control
  logic          in_fire;
  logic          b_move;
  logic          b_valid_q;
  logic [AW-1:0] b_pos_q;
  sample_t       b_dry_q;
  logic          b_zero_q;
  logic          b_fwd_q;
  sample_t       b_fwd_data_q;
  logic          out_valid_q;
  sample_t       out_sample_q;

  logic [AW-1:0] pos_q, pos_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] pos_inc;
  logic [CW-1:0] b_pos_inc;

  sample_t       rd_data_q;
  sample_t       delay_mem_q [DELAY_DEPTH];

  sample_t       wb_sample;

  assign b_move      = b_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !b_valid_q || b_move;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.sample_out = out_sample_q;

  assign pos_inc   = CW'(pos_q) + CW'(1);
  assign b_pos_inc = CW'(b_pos_q) + CW'(1);

  always_comb begin
    pos_d = pos_q;
    if (in_fire) begin
      pos_d = (pos_inc >= len_eff) ? '0 : pos_inc[AW-1:0];
    end
    fill_d = fill_q;
    if (b_move && (b_pos_inc > fill_q)) begin
      fill_d = b_pos_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      fill_q      <= '0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      fill_q <= fill_d;
      if (in_fire) begin
        b_valid_q <= 1'b1;
      end else if (b_move) begin
        b_valid_q <= 1'b0;
      end
      if (b_move) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------- compute stage
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      b_pos_q      <= pos_q;
      b_dry_q      <= in_i.sample_in;
      b_zero_q     <= (CW'(pos_q) >= fill_q);
      // entry being written back this same edge: take the new value
      b_fwd_q      <= b_move && (b_pos_q == pos_q);
      b_fwd_data_q <= wb_sample;
    end
    if (b_move) begin
      out_sample_q <= wb_sample;
    end
  end

  // delay line RAM, one read and one write port
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_data_q <= delay_mem_q[pos_q];
    end
    if (b_move) begin
      delay_mem_q[b_pos_q] <= wb_sample;
    end
  end

  sample_t            delayed;
  logic signed [31:0] prod;
  logic signed [31:0] prod_adj;
  logic signed [16:0] scaled;
  logic signed [17:0] sum;

  always_comb begin
    if (b_fwd_q) begin
      delayed = b_fwd_data_q;
    end else if (b_zero_q) begin
      delayed = '0;
    end else begin
      delayed = rd_data_q;
    end
    prod     = delayed * $signed({1'b0, gain_q});
    // bias negatives so the shift truncates toward zero
    prod_adj = prod[31] ? (prod + 32'sd32767) : prod;
    scaled   = prod_adj[31:15];
    sum      = 18'(b_dry_q) + 18'(scaled);
    if (sum > 18'sd32767) begin
      wb_sample = 16'sh7fff;
    end else if (sum < -18'sd32768) begin
      wb_sample = 16'sh8000;
    end else begin
      wb_sample = sum[15:0];
    end
  end

  // ------------------------------------------------------------ assertions
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(pos_q) < CW'(DELAY_DEPTH))
    else $error("delay position beyond RAM depth");

  a_fill_covers_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_move |=> (fill_q > CW'($past(b_pos_q))))
    else $error("fill mark does not cover written entry");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !b_move) |=> (b_valid_q && $stable(b_pos_q) && $stable(b_dry_q)))
    else $error("compute stage lost a stalled beat");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DELAY_DEPTH))
    else $error("fill mark beyond RAM depth");

endmodule

`default_nettype wire
